### hw/rtl/true_peak_oversampling_meter_top_assert.svh
// Assertion macros for the true-peak meter checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TRUE_PEAK_OVERSAMPLING_METER_TOP_ASSERT_SVH
`define TRUE_PEAK_OVERSAMPLING_METER_TOP_ASSERT_SVH

// same-cycle implication
`define TPOM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPOM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tpom_pkg.sv
// Shared constants, coefficient tables and control structs of the true-peak meter.
// No dependencies.
package tpom_pkg;

    localparam int TAPS             = 48;
    localparam int TAP_W            = $clog2(TAPS);
    localparam int MAX_CHANNELS_DEF = 5;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int CH_W             = 3;
    localparam int PEAK_W           = 25;
    localparam int COEF_W           = 24;
    localparam int ACC_W            = 64;
    localparam int FRAC_SHIFT       = 23;
    localparam int OUT_TDATA_W      = ((2 * PEAK_W + 7) / 8) * 8;
    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

    // configuration port
    localparam int CFG_W      = 3;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERSAMPLE_MODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT   = 1'd1;
    localparam logic [CH_W-1:0]       CHANNEL_COUNT_RST   = 3'd2;

    // item commands and modes
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;
    localparam logic MODE_4X     = 1'b0;
    localparam logic MODE_2X     = 1'b1;

    // coefficient scaling: round half away from zero at 2^23
    localparam longint FS = 64'sd8388608;
    localparam longint D1 = 64'sd10000000;
    localparam longint D2 = 64'sd100000000;
    localparam longint D3 = 64'sd1000000000;
    localparam longint D4 = 64'sd10000000000;
    localparam longint D5 = 64'sd100000000000;
    localparam longint D6 = 64'sd1000000000000;
    localparam longint H1 = D1 / 2;
    localparam longint H2 = D2 / 2;
    localparam longint H3 = D3 / 2;
    localparam longint H4 = D4 / 2;
    localparam longint H5 = D5 / 2;
    localparam longint H6 = D6 / 2;

    // quarter-point phase; three-quarter phase is this reversed
    localparam logic signed [COEF_W-1:0] QUARTER_COEF [TAPS] = '{
        COEF_W'((-64'sd2330790 * FS - H5) / D5),
        COEF_W'(( 64'sd1321291 * FS + H4) / D4),
        COEF_W'((-64'sd3394408 * FS - H4) / D4),
        COEF_W'(( 64'sd6562235 * FS + H4) / D4),
        COEF_W'((-64'sd1094138 * FS - H3) / D3),
        COEF_W'(( 64'sd1665807 * FS + H3) / D3),
        COEF_W'((-64'sd2385230 * FS - H3) / D3),
        COEF_W'(( 64'sd3268371 * FS + H3) / D3),
        COEF_W'((-64'sd4334012 * FS - H3) / D3),
        COEF_W'(( 64'sd5604985 * FS + H3) / D3),
        COEF_W'((-64'sd7109989 * FS - H3) / D3),
        COEF_W'(( 64'sd8886314 * FS + H3) / D3),
        COEF_W'((-64'sd1098403 * FS - H2) / D2),
        COEF_W'(( 64'sd1347264 * FS + H2) / D2),
        COEF_W'((-64'sd1645206 * FS - H2) / D2),
        COEF_W'(( 64'sd2007155 * FS + H2) / D2),
        COEF_W'((-64'sd2456432 * FS - H2) / D2),
        COEF_W'(( 64'sd3031531 * FS + H2) / D2),
        COEF_W'((-64'sd3800644 * FS - H2) / D2),
        COEF_W'(( 64'sd4896667 * FS + H2) / D2),
        COEF_W'((-64'sd6616853 * FS - H2) / D2),
        COEF_W'(( 64'sd9788141 * FS + H2) / D2),
        COEF_W'((-64'sd1788607 * FS - H1) / D1),
        COEF_W'(( 64'sd9000753 * FS + H1) / D1),
        COEF_W'(( 64'sd2993829 * FS + H1) / D1),
        COEF_W'((-64'sd1269367 * FS - H1) / D1),
        COEF_W'(( 64'sd7922398 * FS + H2) / D2),
        COEF_W'((-64'sd5647748 * FS - H2) / D2),
        COEF_W'(( 64'sd4295093 * FS + H2) / D2),
        COEF_W'((-64'sd3385706 * FS - H2) / D2),
        COEF_W'(( 64'sd2724946 * FS + H2) / D2),
        COEF_W'((-64'sd2218943 * FS - H2) / D2),
        COEF_W'(( 64'sd1816976 * FS + H2) / D2),
        COEF_W'((-64'sd1489313 * FS - H2) / D2),
        COEF_W'(( 64'sd1217411 * FS + H2) / D2),
        COEF_W'((-64'sd9891211 * FS - H3) / D3),
        COEF_W'(( 64'sd7961470 * FS + H3) / D3),
        COEF_W'((-64'sd6326144 * FS - H3) / D3),
        COEF_W'(( 64'sd4942202 * FS + H3) / D3),
        COEF_W'((-64'sd3777065 * FS - H3) / D3),
        COEF_W'(( 64'sd2805240 * FS + H3) / D3),
        COEF_W'((-64'sd2006106 * FS - H3) / D3),
        COEF_W'(( 64'sd1362416 * FS + H3) / D3),
        COEF_W'((-64'sd8592768 * FS - H4) / D4),
        COEF_W'(( 64'sd4834383 * FS + H4) / D4),
        COEF_W'((-64'sd2228007 * FS - H4) / D4),
        COEF_W'(( 64'sd6607267 * FS + H5) / D5),
        COEF_W'((-64'sd2537056 * FS - H6) / D6)
    };

    // half-point phase, first half; second half mirrors it
    localparam logic signed [COEF_W-1:0] HALF_COEF [TAPS/2] = '{
        COEF_W'((-64'sd1450055 * FS - H5) / D5),
        COEF_W'(( 64'sd1359163 * FS + H4) / D4),
        COEF_W'((-64'sd3928527 * FS - H4) / D4),
        COEF_W'(( 64'sd8006445 * FS + H4) / D4),
        COEF_W'((-64'sd1375510 * FS - H3) / D3),
        COEF_W'(( 64'sd2134915 * FS + H3) / D3),
        COEF_W'((-64'sd3098103 * FS - H3) / D3),
        COEF_W'(( 64'sd4286860 * FS + H3) / D3),
        COEF_W'((-64'sd5726614 * FS - H3) / D3),
        COEF_W'(( 64'sd7448018 * FS + H3) / D3),
        COEF_W'((-64'sd9489286 * FS - H3) / D3),
        COEF_W'(( 64'sd1189966 * FS + H2) / D2),
        COEF_W'((-64'sd1474471 * FS - H2) / D2),
        COEF_W'(( 64'sd1811472 * FS + H2) / D2),
        COEF_W'((-64'sd2213828 * FS - H2) / D2),
        COEF_W'(( 64'sd2700557 * FS + H2) / D2),
        COEF_W'((-64'sd3301023 * FS - H2) / D2),
        COEF_W'(( 64'sd4062971 * FS + H2) / D2),
        COEF_W'((-64'sd5069345 * FS - H2) / D2),
        COEF_W'(( 64'sd6477499 * FS + H2) / D2),
        COEF_W'((-64'sd8625619 * FS - H2) / D2),
        COEF_W'(( 64'sd1239454 * FS + H1) / D1),
        COEF_W'((-64'sd2101678 * FS - H1) / D1),
        COEF_W'(( 64'sd6359382 * FS + H1) / D1)
    };

    function automatic logic signed [COEF_W-1:0] coef_quarter(input logic [TAP_W-1:0] tap);
        return QUARTER_COEF[tap];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_three(input logic [TAP_W-1:0] tap);
        logic [TAP_W-1:0] idx;
        idx = TAP_W'(TAPS - 1) - tap;
        return QUARTER_COEF[idx];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_half(input logic [TAP_W-1:0] tap);
        logic [TAP_W-1:0] idx;
        idx = (tap < TAP_W'(TAPS / 2)) ? tap : TAP_W'(TAPS - 1) - tap;
        return HALF_COEF[idx[TAP_W-2:0]];
    endfunction

    // controller to datapath
    typedef struct packed {
        logic             accept_item;
        logic             accept_clear;
        logic             accept_bad;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             mag_en;
        logic             peak_en;
        logic             out_load;
    } tpom_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic out_free;
    } tpom_status_t;

endpackage

### hw/rtl/tpom_ctrl.sv
// Sequencer of the true-peak meter: accept, tap sweep, drain, magnitude, peak, output.
// Depends on tpom_pkg.
module tpom_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  tpom_pkg::tpom_status_t status,
    output tpom_pkg::tpom_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MAG   = 3'd3;
    localparam logic [2:0] ST_PEAK  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [tpom_pkg::TAP_W-1:0] LAST_TAP  = tpom_pkg::TAP_W'(tpom_pkg::TAPS - 1);
    localparam logic [tpom_pkg::TAP_W-1:0] LAST_DRAIN = tpom_pkg::TAP_W'(1);

    logic [2:0]                  state_reg, state_next;
    logic [tpom_pkg::TAP_W-1:0]  cnt_reg, cnt_next;
    logic                        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmd              = '0;
        cmd.tap          = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (in_cmd == tpom_pkg::CMD_CLEAR)
                    begin
                        cmd.accept_clear = 1'b1;
                        state_next       = ST_OUT;
                    end
                    else if (status.bad)
                    begin
                        cmd.accept_bad = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        cmd.accept_item = 1'b1;
                        state_next      = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (cnt_reg == LAST_TAP)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == LAST_DRAIN)
                begin
                    state_next = ST_MAG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAG:
            begin
                cmd.mag_en = 1'b1;
                state_next = ST_PEAK;
            end
            ST_PEAK:
            begin
                cmd.peak_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/tpom_dp.sv
// Datapath of the true-peak meter: config registers, delay-line memory, three MAC lanes,
// magnitude and peak logic, output register. Depends on tpom_pkg.
module tpom_dp #(
    parameter int MAX_CHANNELS = tpom_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = tpom_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tpom_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [tpom_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic [tpom_pkg::CH_W-1:0]             in_channel,
    input  logic signed [SAMPLE_BITS-1:0]         in_sample,
    input  tpom_pkg::tpom_cmd_t                   cmd,
    output tpom_pkg::tpom_status_t                status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tpom_pkg::OUT_TDATA_W-1:0]      out_data,
    output logic                                  out_bad
);

    localparam int TAPS   = tpom_pkg::TAPS;
    localparam int TAP_W  = tpom_pkg::TAP_W;
    localparam int DEPTH  = MAX_CHANNELS * TAPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CHI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_BITS + tpom_pkg::COEF_W;
    localparam int ACC_W  = tpom_pkg::ACC_W;
    localparam int PEAK_W = tpom_pkg::PEAK_W;
    localparam int PAD_W  = tpom_pkg::OUT_TDATA_W - 2 * PEAK_W;

    // config registers
    logic                        mode_reg;
    logic [tpom_pkg::CH_W-1:0]   count_reg;

    // delay lines
    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]              valid_reg;
    logic [TAP_W-1:0]              wp_reg [MAX_CHANNELS];

    // item registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CHI_W-1:0]              ch_reg;
    logic [TAP_W-1:0]              wp_cur_reg;

    // pipeline
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic                          vld_d1_reg, v1_reg, new_d1_reg;
    logic [TAP_W-1:0]              tap_d1_reg;
    logic signed [PROD_W-1:0]      pq_reg, ph_reg, pt_reg;
    logic                          v2_reg;
    logic signed [ACC_W-1:0]       accq_reg, acch_reg, acct_reg;

    // peaks
    logic [PEAK_W-1:0] mx_reg, mq_reg, mh_reg, mt_reg;
    logic [PEAK_W-1:0] item_pk_reg, peak_hold_reg;
    logic              bad_reg;
    logic [PEAK_W-1:0] pk_next;

    logic [3:0]        limit;
    logic [CHI_W-1:0]  ch_in;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [TAP_W:0]    slot_sum;
    logic [TAP_W-1:0]  slot;
    logic signed [SAMPLE_BITS-1:0] operand;
    logic [SAMPLE_BITS:0] x_abs;
    logic signed [SAMPLE_BITS:0]   x_ext;

    // channel check: count above the channel limit acts as the limit
    assign limit = ({1'b0, count_reg} > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS)
                                                         : {1'b0, count_reg};
    assign status.bad      = ({1'b0, in_channel} >= limit);
    assign status.out_free = !out_valid || out_ready;
    assign ch_in           = in_channel[CHI_W-1:0];

    assign wr_addr = ADDR_W'(ch_in) * ADDR_W'(TAPS) + ADDR_W'(wp_reg[ch_in]);

    // oldest tap sits just past the write slot
    assign slot_sum = {1'b0, wp_cur_reg} + (TAP_W+1)'(1) + {1'b0, cmd.tap};
    assign slot     = (slot_sum >= (TAP_W+1)'(TAPS)) ? TAP_W'(slot_sum - (TAP_W+1)'(TAPS))
                                                     : slot_sum[TAP_W-1:0];
    assign rd_addr  = ADDR_W'(ch_reg) * ADDR_W'(TAPS) + ADDR_W'(slot);

    // tap operand: newest sample bypasses memory, unwritten entries read as zero
    assign operand = new_d1_reg ? x_reg : (vld_d1_reg ? rd_reg : '0);

    function automatic logic [PEAK_W-1:0] sat64(input logic [63:0] v);
        return (v > 64'(tpom_pkg::PEAK_MAX)) ? tpom_pkg::PEAK_MAX : v[PEAK_W-1:0];
    endfunction

    function automatic logic [PEAK_W-1:0] acc_mag(input logic signed [ACC_W-1:0] a);
        logic [63:0] m;
        m = a[ACC_W-1] ? 64'(-a) : 64'(a);
        return sat64((m + (64'd1 << (tpom_pkg::FRAC_SHIFT - 1))) >> tpom_pkg::FRAC_SHIFT);
    endfunction

    function automatic logic [PEAK_W-1:0] max2(input logic [PEAK_W-1:0] a,
                                                input logic [PEAK_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign x_ext = {x_reg[SAMPLE_BITS-1], x_reg};
    assign x_abs = x_ext[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-x_ext) : x_ext;

    // largest of sample and interpolated points
    always_comb
    begin
        if (mode_reg == tpom_pkg::MODE_4X)
        begin
            pk_next = max2(max2(mx_reg, mq_reg), max2(mh_reg, mt_reg));
        end
        else
        begin
            pk_next = max2(mx_reg, mh_reg);
        end
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tpom_pkg::MODE_4X;
            count_reg <= tpom_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tpom_pkg::REG_OVERSAMPLE_MODE: mode_reg  <= cfg_wdata[0];
                tpom_pkg::REG_CHANNEL_COUNT:   count_reg <= cfg_wdata;
                default:                       mode_reg  <= mode_reg;
            endcase
        end
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (cmd.accept_item)
        begin
            mem[wr_addr] <= in_sample;
        end
        rd_reg <= mem[rd_addr];
    end

    // valid bits and write pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                wp_reg[c] <= '0;
            end
        end
        else if (cmd.accept_clear)
        begin
            valid_reg <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                wp_reg[c] <= '0;
            end
        end
        else if (cmd.accept_item)
        begin
            valid_reg[wr_addr] <= 1'b1;
            wp_reg[ch_in]      <= (wp_reg[ch_in] == TAP_W'(TAPS - 1)) ? '0
                                                                      : wp_reg[ch_in] + 1'b1;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept_item)
        begin
            x_reg      <= in_sample;
            ch_reg     <= ch_in;
            wp_cur_reg <= wp_reg[ch_in];
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            vld_d1_reg <= 1'b0;
            new_d1_reg <= 1'b0;
            tap_d1_reg <= '0;
        end
        else
        begin
            v1_reg     <= cmd.issue;
            v2_reg     <= v1_reg;
            vld_d1_reg <= valid_reg[rd_addr];
            new_d1_reg <= (cmd.tap == TAP_W'(TAPS - 1));
            tap_d1_reg <= cmd.tap;
        end
    end

    // products, one per phase lane
    always_ff @(posedge clk)
    begin
        pq_reg <= operand * tpom_pkg::coef_quarter(tap_d1_reg);
        ph_reg <= operand * tpom_pkg::coef_half(tap_d1_reg);
        pt_reg <= operand * tpom_pkg::coef_three(tap_d1_reg);
    end

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.accept_item)
        begin
            accq_reg <= '0;
            acch_reg <= '0;
            acct_reg <= '0;
        end
        else if (v2_reg)
        begin
            accq_reg <= accq_reg + ACC_W'(pq_reg);
            acch_reg <= acch_reg + ACC_W'(ph_reg);
            acct_reg <= acct_reg + ACC_W'(pt_reg);
        end
    end

    // magnitudes
    always_ff @(posedge clk)
    begin
        if (cmd.mag_en)
        begin
            mx_reg <= sat64(64'(x_abs));
            mq_reg <= acc_mag(accq_reg);
            mh_reg <= acc_mag(acch_reg);
            mt_reg <= acc_mag(acct_reg);
        end
    end

    // item and running peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_pk_reg   <= '0;
            peak_hold_reg <= '0;
            bad_reg       <= 1'b0;
        end
        else if (cmd.accept_clear)
        begin
            item_pk_reg   <= '0;
            peak_hold_reg <= '0;
            bad_reg       <= 1'b0;
        end
        else if (cmd.accept_bad)
        begin
            item_pk_reg <= '0;
            bad_reg     <= 1'b1;
        end
        else if (cmd.accept_item)
        begin
            bad_reg <= 1'b0;
        end
        else if (cmd.peak_en)
        begin
            item_pk_reg   <= pk_next;
            peak_hold_reg <= max2(peak_hold_reg, pk_next);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data <= {{PAD_W{1'b0}}, peak_hold_reg, item_pk_reg};
            out_bad  <= bad_reg;
        end
    end

endmodule

### hw/rtl/true_peak_oversampling_meter_top.sv
// Top level of the true-peak meter: controller plus datapath.
// Depends on tpom_pkg, tpom_ctrl, tpom_dp.
//
//  channel | direction | tdata (low bit up)                 | tuser
//  s_      | in        | channel[2:0], sample[SAMPLE_BITS]  | cmd
//  m_      | out       | item_peak[24:0], running_peak[24:0]| bad_channel
//  cfg_    | in        | index 0 oversample_mode, 1 channel_count
//
// A sample item runs from accept to result through an accept state, a sweep of 48 taps
// on the single delay-line read port (three phase MACs run side by side), a pipeline
// drain, then magnitude, peak and output-load states. Clear and rejected-channel items
// go from accept straight to output load. Reset clears valid bits at once.
// A new item is accepted as soon as the previous result sits in the output register.
module true_peak_oversampling_meter_top #(
    parameter int MAX_CHANNELS = tpom_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = tpom_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // channel [2:0], sample above it, zero padded to bytes
    input  logic [((tpom_pkg::CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // item_peak [24:0], running_peak [49:25], zero padded
    output logic [tpom_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // bad_channel
    output logic                                   m_tuser,
    input  logic                                   cfg_we,
    input  logic [tpom_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [tpom_pkg::CFG_W-1:0]             cfg_wdata
);

    localparam int CH_W = tpom_pkg::CH_W;

    tpom_pkg::tpom_cmd_t    cmd;
    tpom_pkg::tpom_status_t status;

    logic [CH_W-1:0]               in_channel;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    assign in_channel = s_tdata[CH_W-1:0];
    assign in_sample  = s_tdata[CH_W + SAMPLE_BITS - 1:CH_W];

    tpom_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpom_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_channel (in_channel),
        .in_sample  (in_sample),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_bad    (m_tuser)
    );

endmodule

### hw/rtl/tpom_checker.sv
// Port-level checks of the true-peak meter, bound to the top level.
// Depends on tpom_pkg and true_peak_oversampling_meter_top_assert.svh.
`include "true_peak_oversampling_meter_top_assert.svh"

module tpom_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tpom_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                               m_tuser
);

    // a stalled result stays offered
    `TPOM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // one item at a time: the input closes right after a request
    `TPOM_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken early")

    // rejected channel reports no peak
    `TPOM_ASSERT_IMP(a_bad_zero, m_tvalid && m_tuser, m_tdata[24:0] == 25'd0,
                     "peak on rejected channel")

    // item peak never exceeds the running peak
    `TPOM_ASSERT_IMP(a_peak_order, m_tvalid, m_tdata[24:0] <= m_tdata[49:25],
                     "item peak above running peak")

endmodule

bind true_peak_oversampling_meter_top tpom_checker u_tpom_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### test/true_peak_oversampling_meter_top_tb.sv
// Self-checking testbench for the true-peak meter: a scoreboard class predicts
// item and running peaks from its own polyphase FIR model and checks each result.
// Depends on tpom_pkg and true_peak_oversampling_meter_top.
module true_peak_oversampling_meter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_W        = tpom_pkg::CH_W;
    localparam int TAPS        = tpom_pkg::TAPS;
    localparam int PEAK_W      = tpom_pkg::PEAK_W;
    localparam int CFG_W       = tpom_pkg::CFG_W;
    localparam int CFG_ADDR_W  = tpom_pkg::CFG_ADDR_W;
    localparam int OUT_TDATA_W = tpom_pkg::OUT_TDATA_W;
    localparam int FRAC_SHIFT  = tpom_pkg::FRAC_SHIFT;
    localparam logic [PEAK_W-1:0]     PEAK_MAX            = tpom_pkg::PEAK_MAX;
    localparam logic [CH_W-1:0]       CHANNEL_COUNT_RST   = tpom_pkg::CHANNEL_COUNT_RST;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERSAMPLE_MODE = tpom_pkg::REG_OVERSAMPLE_MODE;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT   = tpom_pkg::REG_CHANNEL_COUNT;
    localparam logic CMD_PROCESS = tpom_pkg::CMD_PROCESS;
    localparam logic CMD_CLEAR   = tpom_pkg::CMD_CLEAR;
    localparam logic MODE_4X     = tpom_pkg::MODE_4X;
    localparam logic MODE_2X     = tpom_pkg::MODE_2X;

    localparam int NCH    = 5;
    localparam int SBITS  = 24;
    localparam int S_W    = ((CH_W + SBITS + 7) / 8) * 8;
    localparam int N_RAND = 1400;

    typedef struct {
        logic [PEAK_W-1:0] item_peak;
        logic [PEAK_W-1:0] running_peak;
        logic              bad_channel;
    } peak_rec_t;

    // peak predictor plus queue of pending peak records
    class peak_scoreboard;
        longint            quarter_tap [TAPS];
        longint            half_tap [TAPS/2];
        longint            history [NCH][TAPS];
        logic [PEAK_W-1:0] peak_hold;
        logic              mode;
        logic [CH_W-1:0]   ch_count;
        peak_rec_t         pending [$];
        int                errors;

        function new();
            longint qm [TAPS] = '{-2330790, 1321291, -3394408, 6562235, -1094138, 1665807,
                -2385230, 3268371, -4334012, 5604985, -7109989, 8886314, -1098403, 1347264,
                -1645206, 2007155, -2456432, 3031531, -3800644, 4896667, -6616853, 9788141,
                -1788607, 9000753, 2993829, -1269367, 7922398, -5647748, 4295093, -3385706,
                2724946, -2218943, 1816976, -1489313, 1217411, -9891211, 7961470, -6326144,
                4942202, -3777065, 2805240, -2006106, 1362416, -8592768, 4834383, -2228007,
                6607267, -2537056};
            int qe [TAPS] = '{5, 4, 4, 4, 3, 3, 3, 3, 3, 3, 3, 3, 2, 2, 2, 2, 2, 2, 2, 2, 2,
                2, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 5, 6};
            longint hm [TAPS/2] = '{-1450055, 1359163, -3928527, 8006445, -1375510, 2134915,
                -3098103, 4286860, -5726614, 7448018, -9489286, 1189966, -1474471, 1811472,
                -2213828, 2700557, -3301023, 4062971, -5069345, 6477499, -8625619, 1239454,
                -2101678, 6359382};
            int he [TAPS/2] = '{5, 4, 4, 4, 3, 3, 3, 3, 3, 3, 3, 2, 2, 2, 2, 2, 2, 2, 2, 2,
                2, 1, 1, 1};
            for (int i = 0; i < TAPS; i++)
                quarter_tap[i] = scale_coef(qm[i], qe[i]);
            for (int i = 0; i < TAPS/2; i++)
                half_tap[i] = scale_coef(hm[i], he[i]);
            clear_state();
            mode     = MODE_4X;
            ch_count = CHANNEL_COUNT_RST;
            errors   = 0;
        endfunction

        // decimal mantissa times 10^-(6+e), to Q23, halves away from zero
        function longint scale_coef(longint m, int e);
            longint d;
            d = 1;
            for (int k = 0; k < 6 + e; k++)
                d = d * 10;
            return (m * 64'sd8388608 + (m < 0 ? -(d / 2) : d / 2)) / d;
        endfunction

        function void clear_state();
            foreach (history[c, t])
                history[c][t] = 0;
            peak_hold = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] val);
            if (addr == REG_OVERSAMPLE_MODE)
                mode = val[0];
            else if (addr == REG_CHANNEL_COUNT)
                ch_count = val;
        endfunction

        function logic [PEAK_W-1:0] clip(longint v);
            return (v > longint'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(v);
        endfunction

        // 0 = quarter, 1 = half, 2 = three-quarter point
        function logic [PEAK_W-1:0] interp_mag(int c, int which);
            longint acc, co;
            acc = 0;
            for (int i = 0; i < TAPS; i++)
            begin
                if (which == 0)
                    co = quarter_tap[i];
                else if (which == 2)
                    co = quarter_tap[TAPS - 1 - i];
                else
                    co = (i < TAPS/2) ? half_tap[i] : half_tap[TAPS - 1 - i];
                acc += history[c][i] * co;
            end
            if (acc < 0)
                acc = -acc;
            return clip((acc + 64'sd4194304) >>> FRAC_SHIFT);
        endfunction

        // note an accepted request and queue its expected peaks
        function void note_request(logic cmd, logic [CH_W-1:0] ch, logic [SBITS-1:0] smp);
            peak_rec_t         r;
            int                limit;
            longint            x;
            logic [PEAK_W-1:0] pk, p;
            limit = (ch_count > NCH) ? NCH : ch_count;
            if (cmd == CMD_CLEAR)
            begin
                clear_state();
                r = '{'0, '0, 1'b0};
            end
            else if (ch >= limit)
                r = '{'0, peak_hold, 1'b1};
            else
            begin
                x = longint'($signed(smp));
                history[ch][TAPS-1] = x;
                pk = clip(x < 0 ? -x : x);
                for (int w = 0; w < 3; w++)
                begin
                    if (mode == MODE_4X || w == 1)
                    begin
                        p = interp_mag(ch, w);
                        if (p > pk)
                            pk = p;
                    end
                end
                for (int i = 0; i < TAPS - 1; i++)
                    history[ch][i] = history[ch][i + 1];
                if (pk > peak_hold)
                    peak_hold = pk;
                r = '{pk, peak_hold, 1'b0};
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [PEAK_W-1:0] ip, logic [PEAK_W-1:0] rp, logic bad);
            peak_rec_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: item_peak %0d running_peak %0d", ip, rp);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ip !== e.item_peak)
            begin
                $error("item_peak expected %0d actual %0d", e.item_peak, ip);
                errors++;
            end
            if (rp !== e.running_peak)
            begin
                $error("running_peak expected %0d actual %0d", e.running_peak, rp);
                errors++;
            end
            if (bad !== e.bad_channel)
            begin
                $error("bad_channel expected %0d actual %0d", e.bad_channel, bad);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    peak_scoreboard sb = new();
    int             rx_hold = 0;   // long receiver hold-off, counted down by the receiver
    bit             rx_gaps = 1'b1;
    bit             tx_gaps = 1'b1;
    int             n_sent = 0;    // requests accepted so far

    true_peak_oversampling_meter_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // receiver: check results, random ready with optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[PEAK_W-1:0], m_tdata[2*PEAK_W-1:PEAK_W], m_tuser);
            if (rx_hold > 0)
            begin
                rx_hold <= rx_hold - 1;
                m_tready <= 1'b0;
            end
            else if (!rx_gaps)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) < 75) || ($urandom_range(0, 9) == 0);
        end
    end

    task automatic send_request(logic cmd, logic [CH_W-1:0] ch, logic [SBITS-1:0] smp);
        int g;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_W'({smp, ch});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, ch, smp);
        n_sent++;
        g = tx_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(addr, val);
    endtask

    function automatic logic [SBITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        else if (r < 25)
            return SBITS'($urandom_range(0, 64)) ^ {SBITS{$urandom_range(0, 1) == 1}};
        return SBITS'($urandom());
    endfunction

    // stimulus
    initial
    begin
        int limit, r, sgn, step, phase_start;
        logic [CH_W-1:0] ch;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, impulse response, clear, rejected channels
        send_request(CMD_PROCESS, 0, 24'h7fffff);
        send_request(CMD_PROCESS, 0, 24'h800000);
        send_request(CMD_PROCESS, 1, 24'h000000);
        send_request(CMD_PROCESS, 2, 24'h123456);
        send_request(CMD_PROCESS, 7, 24'h7fffff);
        repeat (4) send_request(CMD_PROCESS, 0, 24'h000000);
        send_request(CMD_CLEAR, 7, 24'hffffff);
        send_request(CMD_PROCESS, 1, 24'h400000);
        for (int i = 0; i < 6; i++)
            send_request(CMD_PROCESS, 1, (i % 2) ? 24'h7fffff : 24'h800000);
        write_reg(REG_OVERSAMPLE_MODE, MODE_2X);
        write_reg(REG_CHANNEL_COUNT, 3'd5);
        send_request(CMD_PROCESS, 4, 24'h800000);
        send_request(CMD_PROCESS, 4, 24'h7fffff);
        send_request(CMD_PROCESS, 5, 24'h000001);
        write_reg(REG_CHANNEL_COUNT, 3'd0);
        send_request(CMD_PROCESS, 0, 24'h7fffff);
        write_reg(REG_CHANNEL_COUNT, 3'd7);
        send_request(CMD_PROCESS, 4, 24'h1fffff);
        send_request(CMD_PROCESS, 6, 24'h1fffff);
        write_reg(REG_CHANNEL_COUNT, 3'd1);
        send_request(CMD_PROCESS, 1, 24'h000000);

        // random phases, each with its own setting
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_OVERSAMPLE_MODE, CFG_W'($urandom_range(0, 1)));
            r = $urandom_range(0, 9);
            write_reg(REG_CHANNEL_COUNT, (r == 0) ? CFG_W'($urandom_range(0, 7))
                                                  : CFG_W'($urandom_range(1, 5)));
            limit = (sb.ch_count > NCH) ? NCH : sb.ch_count;
            rx_gaps = (ph != 2);
            tx_gaps = (ph != 3);
            phase_start = n_sent;
            step = 0;
            while (n_sent - phase_start < N_RAND / 7)
            begin
                if (ph == 1 && step == 50)
                    rx_hold = 700;
                if (ph == 4 && step == 100)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_request(CMD_CLEAR, CH_W'($urandom()), SBITS'($urandom()));
                else if (r < 9 || limit == 0)
                    send_request(CMD_PROCESS, CH_W'($urandom()), pick_sample());
                else
                begin
                    ch = CH_W'($urandom_range(0, limit - 1));
                    if (r < 30)
                    begin
                        // alternating full-scale run drives the interpolated peaks high
                        sgn = $urandom_range(0, 1);
                        repeat ($urandom_range(4, 12))
                        begin
                            send_request(CMD_PROCESS, ch, sgn ? 24'h800000 : 24'h7fffff);
                            sgn = !sgn;
                        end
                    end
                    else
                        send_request(CMD_PROCESS, ch, pick_sample());
                end
                step++;
            end
        end

        drain();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
